>>> rtl/lagrange_basis_1d_eval_unit_defines.svh
// Assertion macros for the port checker file.
`ifndef LAGRANGE_BASIS_1D_EVAL_UNIT_DEFINES_SVH
`define LAGRANGE_BASIS_1D_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define LBE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbe check failed");

// Next-cycle implication, off while reset is asserted.
`define LBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbe check failed");

// Next-cycle implication that also holds through reset.
`define LBE_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbe check failed");

`endif

>>> rtl/lbe_pkg.sv
package lbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 18;
  localparam int DEG_W     = 3;
  localparam int NODE_W    = 3;
  localparam int OUT_W     = 24;
  localparam int COEF_W    = 13;
  localparam int ACC_W     = 46;
  localparam int PROD_W    = ACC_W + COORD_W;
  localparam int NUM_COEF  = 5;
  localparam int NUM_LANE  = 3;
  localparam int NUM_STEPS = NUM_COEF - 1;

  localparam logic [DEG_W-1:0] MAX_DEGREE = 3'd4;

  // lanes
  localparam int LANE_VAL  = 0;
  localparam int LANE_SLP  = 1;
  localparam int LANE_CURV = 2;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   res_t;

  typedef coef_t [NUM_COEF-1:0] row_t;
  typedef coef_t [NUM_LANE-1:0][NUM_COEF-1:0] coef_set_t;

  // accumulator clamp +-2^44, rounding half
  localparam prod_t ACC_MAX  = prod_t'(64'h0000_1000_0000_0000);
  localparam prod_t ACC_MIN  = -ACC_MAX;
  localparam prod_t RND_HALF = prod_t'(64'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    coord_t            coord;
  } tag_t;

  // Horner accumulator stage: coef[l][NUM_STEPS-1] is the next coefficient
  typedef struct packed {
    tag_t                                    tag;
    acc_t [NUM_LANE-1:0]                     acc;
    coef_t [NUM_LANE-1:0][NUM_STEPS-1:0]     coef;
  } hstage_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic                last;
    res_t [NUM_LANE-1:0] res;
  } result_t;

  function automatic row_t mk_row(input int a0, input int a1, input int a2,
                                  input int a3, input int a4);
    row_t r;
    r[0] = COEF_W'(a0);
    r[1] = COEF_W'(a1);
    r[2] = COEF_W'(a2);
    r[3] = COEF_W'(a3);
    r[4] = COEF_W'(a4);
    return r;
  endfunction

  // value polynomial coefficients (xi^0..xi^4) over 48
  function automatic row_t poly_row(input logic [DEG_W-1:0] deg,
                                    input logic [NODE_W-1:0] node);
    row_t r;
    case ({deg, node})
      {3'd0, 3'd0}: r = mk_row( 48,   0,    0,   0,    0);
      {3'd1, 3'd0}: r = mk_row( 24, -24,    0,   0,    0);
      {3'd1, 3'd1}: r = mk_row( 24,  24,    0,   0,    0);
      {3'd2, 3'd0}: r = mk_row(  0, -24,   24,   0,    0);
      {3'd2, 3'd1}: r = mk_row( 48,   0,  -48,   0,    0);
      {3'd2, 3'd2}: r = mk_row(  0,  24,   24,   0,    0);
      {3'd3, 3'd0}: r = mk_row( -3,   3,   27, -27,    0);
      {3'd3, 3'd1}: r = mk_row( 27, -81,  -27,  81,    0);
      {3'd3, 3'd2}: r = mk_row( 27,  81,  -27, -81,    0);
      {3'd3, 3'd3}: r = mk_row( -3,  -3,   27,  27,    0);
      {3'd4, 3'd0}: r = mk_row(  0,   8,   -8, -32,   32);
      {3'd4, 3'd1}: r = mk_row(  0, -64,  128,  64, -128);
      {3'd4, 3'd2}: r = mk_row( 48,   0, -240,   0,  192);
      {3'd4, 3'd3}: r = mk_row(  0,  64,  128, -64, -128);
      {3'd4, 3'd4}: r = mk_row(  0,  -8,   -8,  32,   32);
      default:      r = '0;
    endcase
    return r;
  endfunction

  // value, first and second derivative coefficients, zero padded on top
  function automatic coef_set_t lbe_coefs(input logic [DEG_W-1:0] deg,
                                          input logic [NODE_W-1:0] node);
    row_t      r;
    coef_set_t s;
    r = poly_row(deg, node);
    s = '0;
    for (int k = 0; k < NUM_COEF; k++) begin
      s[LANE_VAL][k] = r[k];
    end
    for (int k = 0; k < NUM_COEF - 1; k++) begin
      s[LANE_SLP][k] = COEF_W'((k + 1) * int'($signed(r[k+1])));
    end
    for (int k = 0; k < NUM_COEF - 2; k++) begin
      s[LANE_CURV][k] = COEF_W'((k + 1) * (k + 2) * int'($signed(r[k+2])));
    end
    return s;
  endfunction

endpackage

>>> rtl/lbe_node_seq.sv
module lbe_node_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  lbe_pkg::coord_t           in_coord,
  input  logic [lbe_pkg::DEG_W-1:0] degree,
  output logic                      in_ready,
  output logic                      s0_valid_r,
  output lbe_pkg::hstage_t          s0_r
);
  import lbe_pkg::*;

  logic                busy_r, busy_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [DEG_W-1:0]    deg_r, deg_nxt;
  coord_t              coord_r, coord_nxt;
  logic                last_node;
  logic                accept;
  coef_set_t           cset;
  hstage_t             s0_nxt;

  assign last_node = (node_r == deg_r);
  assign in_ready  = en && (!busy_r || last_node);
  assign accept    = in_valid && in_ready;

  always_comb begin
    busy_nxt  = busy_r;
    node_nxt  = node_r;
    deg_nxt   = deg_r;
    coord_nxt = coord_r;
    if (en && busy_r) begin
      if (last_node) begin
        busy_nxt = 1'b0;
      end else begin
        node_nxt = node_r + 1'b1;
      end
    end
    if (accept) begin
      busy_nxt  = (degree <= MAX_DEGREE);  // no nodes above degree four
      node_nxt  = '0;
      deg_nxt   = degree;
      coord_nxt = in_coord;
    end
  end

  // stage 0: coefficient lookup and Horner seed
  always_comb begin
    cset = lbe_coefs(deg_r, node_r);
    s0_nxt.tag.node  = node_r;
    s0_nxt.tag.last  = last_node;
    s0_nxt.tag.coord = coord_r;
    for (int l = 0; l < NUM_LANE; l++) begin
      s0_nxt.acc[l] = acc_t'($signed(cset[l][NUM_COEF-1])) <<< FRAC_BITS;
      for (int k = 0; k < NUM_STEPS; k++) begin
        s0_nxt.coef[l][k] = cset[l][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      s0_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (en) begin
        s0_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    deg_r   <= deg_nxt;
    coord_r <= coord_nxt;
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

endmodule

>>> rtl/lbe_horner_step.sv
module lbe_horner_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  lbe_pkg::hstage_t in_s,
  output logic             out_valid_r,
  output lbe_pkg::hstage_t out_s_r
);
  import lbe_pkg::*;

  typedef struct packed {
    tag_t                                tag;
    prod_t [NUM_LANE-1:0]                prod;
    coef_t [NUM_LANE-1:0][NUM_STEPS-1:0] coef;
  } pstage_t;

  logic    pv_r;
  pstage_t p_r, p_nxt;
  hstage_t out_nxt;

  // multiply stage
  always_comb begin
    p_nxt.tag  = in_s.tag;
    p_nxt.coef = in_s.coef;
    for (int l = 0; l < NUM_LANE; l++) begin
      p_nxt.prod[l] = prod_t'($signed(in_s.acc[l])) * prod_t'($signed(in_s.tag.coord));
    end
  end

  // round, add next coefficient, clamp
  always_comb begin
    prod_t t;
    prod_t sum;
    out_nxt.tag = p_r.tag;
    for (int l = 0; l < NUM_LANE; l++) begin
      t   = ($signed(p_r.prod[l]) + RND_HALF) >>> FRAC_BITS;
      sum = t + (prod_t'($signed(p_r.coef[l][NUM_STEPS-1])) <<< FRAC_BITS);
      if (sum > ACC_MAX) begin
        sum = ACC_MAX;
      end else if (sum < ACC_MIN) begin
        sum = ACC_MIN;
      end
      out_nxt.acc[l]  = acc_t'(sum);
      out_nxt.coef[l] = {p_r.coef[l][NUM_STEPS-2:0], coef_t'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= in_valid;
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      out_s_r <= out_nxt;
    end
  end

endmodule

>>> rtl/lbe_scale.sv
module lbe_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  lbe_pkg::hstage_t in_s,
  output logic             out_valid_r,
  output lbe_pkg::result_t out_r
);
  import lbe_pkg::*;

  // floor((acc + 24) / 48) = floor(floor((acc + 24) / 16) / 3)
  localparam int    DIV_SHIFT = 4;
  localparam prod_t RND_48    = prod_t'(24);
  localparam prod_t DIV_BIAS  = prod_t'(3 * (2 ** (OUT_W - 1)));
  localparam int    U_W       = OUT_W + 2;
  localparam int    RECIP_K   = 28;
  localparam int    RECIP_W   = 27;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((2 ** RECIP_K) + 2) / 3);
  localparam int    M_W       = U_W + RECIP_W;
  localparam int    Q_W       = OUT_W + 1;
  localparam logic signed [Q_W:0] Q_OFS = (Q_W + 1)'(2 ** (OUT_W - 1));
  localparam logic signed [Q_W:0] Q_MAX = (Q_W + 1)'((2 ** (OUT_W - 1)) - 1);

  typedef struct packed {
    logic [NODE_W-1:0]            node;
    logic                         last;
    logic [NUM_LANE-1:0][U_W-1:0] u;
  } ustage_t;

  typedef struct packed {
    logic [NODE_W-1:0]            node;
    logic                         last;
    logic [NUM_LANE-1:0][M_W-1:0] m;
  } mstage_t;

  logic    uv_r, mv_r;
  ustage_t u_r, u_nxt;
  mstage_t m_r, m_nxt;
  result_t out_nxt;

  // offset so the divide by three works on a non-negative value below 2^26
  always_comb begin
    prod_t s;
    u_nxt.node = in_s.tag.node;
    u_nxt.last = in_s.tag.last;
    for (int l = 0; l < NUM_LANE; l++) begin
      s = (prod_t'($signed(in_s.acc[l])) + RND_48) >>> DIV_SHIFT;
      if (s > DIV_BIAS) begin
        s = DIV_BIAS;
      end else if (s < -DIV_BIAS) begin
        s = -DIV_BIAS;
      end
      u_nxt.u[l] = U_W'(s + DIV_BIAS);
    end
  end

  always_comb begin
    m_nxt.node = u_r.node;
    m_nxt.last = u_r.last;
    for (int l = 0; l < NUM_LANE; l++) begin
      m_nxt.m[l] = M_W'(u_r.u[l]) * M_W'(RECIP_M);
    end
  end

  always_comb begin
    logic signed [Q_W:0] q;
    out_nxt.node = m_r.node;
    out_nxt.last = m_r.last;
    for (int l = 0; l < NUM_LANE; l++) begin
      q = $signed({1'b0, m_r.m[l][RECIP_K +: Q_W]}) - Q_OFS;
      if (q > Q_MAX) begin
        q = Q_MAX;
      end
      out_nxt.res[l] = res_t'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      uv_r        <= in_valid;
      mv_r        <= uv_r;
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r   <= u_nxt;
      m_r   <= m_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/lagrange_basis_1d_eval_unit.sv
// Throughput: one node result per cycle while the output is not stalled; a coordinate
//   yields degree+1 node results (5 at degree four), issued one node per cycle by the node sequencer.
// A coordinate taken while degree is above four is consumed and produces no node results.
// Reset (rst_n low, synchronous) empties the pipeline and sets degree to 1.
module lagrange_basis_1d_eval_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [17:0] coordinate, [23:18] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [2:0] node_index, [26:3] value,
                                  // [50:27] slope, [74:51] curvature, [79:75] zero
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbe_pkg::*;

  // register word index (byte address bit 2)
  localparam logic REG_DEGREE = 1'b0;
  localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd1;

  logic [DEG_W-1:0] degree_r, degree_nxt;
  logic             cfg_wr;
  logic             en;

  // Pipeline: sequencer/lookup (1) -> four Horner steps (2 each) -> scale (3).
  hstage_t          hs   [NUM_STEPS+1];
  logic             hv   [NUM_STEPS+1];
  result_t          res_r;

  // ---------------------------------------------------------------------
  // Configuration: one register, write on access phase, pready tied high
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_DEGREE);
  assign degree_nxt = cfg_wr ? cfg_pwdata[DEG_W-1:0] : degree_r;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DEGREE) begin
      cfg_prdata = {{(32-DEG_W){1'b0}}, degree_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
    end else begin
      degree_r <= degree_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: every stage moves unless a result is held at the output
  // register. Bubbles travel as cleared valid bits.
  // ---------------------------------------------------------------------
  assign en = !out_tvalid || out_tready;

  lbe_node_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .in_coord   (coord_t'(in_tdata[COORD_W-1:0])),
    .degree     (degree_r),
    .in_ready   (in_tready),
    .s0_valid_r (hv[0]),
    .s0_r       (hs[0])
  );

  // Horner chain: each step multiplies by xi, then rounds and adds the
  // next lower coefficient for all three lanes (value, slope, curvature).
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    lbe_horner_step u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (hv[i]),
      .in_s        (hs[i]),
      .out_valid_r (hv[i+1]),
      .out_s_r     (hs[i+1])
    );
  end

  // divide by 48 with rounding, saturate to Q7.16; last stage is the
  // output register
  lbe_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (hv[NUM_STEPS]),
    .in_s        (hs[NUM_STEPS]),
    .out_valid_r (out_tvalid),
    .out_r       (res_r)
  );

  assign out_tdata = {5'b0, res_r.res[LANE_CURV], res_r.res[LANE_SLP],
                      res_r.res[LANE_VAL], res_r.node};
  assign out_tlast = res_r.last;

endmodule

>>> rtl/lbe_port_checker.sv
`include "lagrange_basis_1d_eval_unit_defines.svh"

module lbe_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tlast
);

  // nothing comes out in the cycle after reset
  `LBE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  // a stalled item holds
  `LBE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // node index never exceeds four
  `LBE_ASSERT_IMPL(a_node_range, clk, rst_n, out_tvalid, out_tdata[2:0] <= 3'd4)

  // node four always closes its coordinate
  `LBE_ASSERT_IMPL(a_node4_last, clk, rst_n, out_tvalid && (out_tdata[2:0] == 3'd4),
    out_tlast)

endmodule

bind lagrange_basis_1d_eval_unit lbe_port_checker u_lbe_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> sim/lagrange_basis_1d_eval_unit_tb.sv
`timescale 1ns / 100ps

// One node result as it leaves the block.
typedef struct packed {
  logic [2:0]     node;
  lbe_pkg::res_t  value;
  lbe_pkg::res_t  slope;
  lbe_pkg::res_t  curvature;
  logic           last;
} node_result_t;

class lagrange_scoreboard;
  localparam int      FRAC    = 16;
  localparam int      DENOM   = 48;
  localparam longint  ACC_LIM = 64'sd1 <<< 44;
  localparam longint  RES_MAX = 64'sd8388607;
  localparam longint  RES_MIN = -64'sd8388608;
  localparam logic [2:0] DEGREE_ADDR = 3'd0;

  bit [2:0]     degree;
  int           failures;
  node_result_t expected_q[$];
  int           basis_tab[15][5];

  function new();
    degree   = 3'd1;
    failures = 0;
    // value polynomials xi^0..xi^4, scaled by 48; degree d starts at row d*(d+1)/2
    basis_tab = '{
      '{ 48,   0,    0,   0,    0}, '{ 24, -24,    0,   0,    0},
      '{ 24,  24,    0,   0,    0}, '{  0, -24,   24,   0,    0},
      '{ 48,   0,  -48,   0,    0}, '{  0,  24,   24,   0,    0},
      '{ -3,   3,   27, -27,    0}, '{ 27, -81,  -27,  81,    0},
      '{ 27,  81,  -27, -81,    0}, '{ -3,  -3,   27,  27,    0},
      '{  0,   8,   -8, -32,   32}, '{  0, -64,  128,  64, -128},
      '{ 48,   0, -240,   0,  192}, '{  0,  64,  128, -64, -128},
      '{  0,  -8,   -8,  32,   32}};
  endfunction

  function void write_register(logic [2:0] addr, logic [31:0] data);
    if (addr == DEGREE_ADDR) degree = data[2:0];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function longint clamp_acc(longint v);
    if (v > ACC_LIM) return ACC_LIM;
    if (v < -ACC_LIM) return -ACC_LIM;
    return v;
  endfunction

  // Horner in fixed point, then /48 with round half up, saturated to 24 bits
  function lbe_pkg::res_t horner(longint a[5], int n, longint c);
    longint acc;
    longint q;
    if (n <= 0) return '0;
    acc = clamp_acc(a[n-1] <<< FRAC);
    for (int k = n - 2; k >= 0; k--) begin
      acc = clamp_acc((a[k] <<< FRAC) + ((acc * c + (64'sd1 <<< (FRAC - 1))) >>> FRAC));
    end
    acc = acc + DENOM / 2;
    q = acc / DENOM;
    if (acc % DENOM != 0 && acc < 0) q = q - 1;
    if (q > RES_MAX) q = RES_MAX;
    if (q < RES_MIN) q = RES_MIN;
    return lbe_pkg::res_t'(q);
  endfunction

  function void note_coordinate(lbe_pkg::coord_t coord);
    longint       c;
    longint       v[5];
    longint       d1[5];
    longint       d2[5];
    int           row;
    int           p;
    node_result_t r;
    if (degree > 3'd4) return;   // degree out of range: coordinate is swallowed
    p = degree;
    c = longint'(coord);
    for (int node = 0; node <= p; node++) begin
      row = p * (p + 1) / 2 + node;
      for (int k = 0; k < 5; k++) begin
        v[k]  = basis_tab[row][k];
        d1[k] = (k < 4) ? (k + 1) * basis_tab[row][k+1] : 0;
        d2[k] = (k < 3) ? (k + 1) * (k + 2) * basis_tab[row][k+2] : 0;
      end
      r.node      = node[2:0];
      r.value     = horner(v, p + 1, c);
      r.slope     = horner(d1, p, c);
      r.curvature = horner(d2, p - 1, c);
      r.last      = (node == p);
      expected_q.push_back(r);
    end
  endfunction

  function void check_result(node_result_t got);
    node_result_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected node result: node %0d value %0d slope %0d curv %0d last %0b",
                 got.node, got.value, got.slope, got.curvature, got.last);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch: expected node %0d value %0d slope %0d curv %0d last %0b",
                 want.node, want.value, want.slope, want.curvature, want.last);
        $display("          got      node %0d value %0d slope %0d curv %0d last %0b",
                 got.node, got.value, got.slope, got.curvature, got.last);
      end
    end
  endfunction
endclass

module lagrange_basis_1d_eval_unit_tb;

  localparam logic [2:0] DEGREE_ADDR   = 3'd0;
  localparam logic [2:0] UNUSED_ADDR   = 3'd4;   // no register here, writes are dropped
  localparam int         SETTLE_CYCLES = 24;     // margin beyond the pipeline latency
  localparam int         SEG_ITEMS     = 25;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [17:0] coordinate, [23:18] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;   // [2:0] node, [26:3] value, [50:27] slope, [74:51] curvature
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // idle rates in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  lagrange_scoreboard basis_sb = new();

  lagrange_basis_1d_eval_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random back-pressure, one update per edge
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor: values read here are the ones the edge just sampled
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      basis_sb.check_result({out_tdata[2:0], out_tdata[26:3], out_tdata[50:27],
                             out_tdata[74:51], out_tlast});
    end
  end

  // Send one coordinate, with random idle cycles ahead of it.
  // Returns right after the edge that accepted the item.
  task automatic push_coord(input lbe_pkg::coord_t coord);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, coord};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    basis_sb.note_coordinate(coord);
  endtask

  // Stop sending and let every expected node result come out, plus margin
  // for coordinates that produce nothing but may still be in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (basis_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    basis_sb.write_register(addr, data);
  endtask

  // Mostly in [-1,1]; some exact ends and some anywhere in the 18-bit range.
  function automatic lbe_pkg::coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return lbe_pkg::coord_t'($urandom());
    if (pick == 1) return lbe_pkg::coord_t'(($urandom_range(0, 2) - 1) * 65536);
    return lbe_pkg::coord_t'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  initial begin
    int send_pct[4];
    int recv_pct[4];
    int deg;
    lbe_pkg::coord_t edge_coords[4];

    send_pct = '{0, 47, 0, 22};
    recv_pct = '{0, 0, 47, 22};
    edge_coords = '{-18'sd65536, 18'sd65536, 18'sd131071, -18'sd131072};

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // degree after reset is linear
    push_coord(18'sd32768);
    settle();
    // write to a hole in the map must not touch degree
    cfg_write(UNUSED_ADDR, 32'd3);
    push_coord(-18'sd32768);
    settle();

    // every degree at both element ends and at the coordinate extremes
    for (int d = 0; d <= 4; d++) begin
      cfg_write(DEGREE_ADDR, d);
      foreach (edge_coords[i]) push_coord(edge_coords[i]);
      settle();
    end

    // degree above four: coordinates vanish
    cfg_write(DEGREE_ADDR, 32'd5);
    push_coord(18'sd12345);
    settle();
    cfg_write(DEGREE_ADDR, 32'd7);
    push_coord(-18'sd1);
    settle();

    // --- random part: four idle phases, four degree settings in each ---
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (int seg = 0; seg < 4; seg++) begin
        if (ph == 0 && seg == 0) deg = 4;
        else if (ph == 0 && seg == 1) deg = 0;
        else if ($urandom_range(0, 7) == 0) deg = $urandom_range(5, 7);
        else deg = $urandom_range(0, 4);
        cfg_write(DEGREE_ADDR, deg);
        for (int i = 0; i < SEG_ITEMS; i++) begin
          // one hold-off mid stream until the block has emptied
          if (seg == 0 && i == 12) settle();
          push_coord(rand_coord());
        end
        settle();
      end
    end

    settle();
    if (basis_sb.failures == 0 && basis_sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog: set far beyond the expected run time
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
